>>> src/gdd_pkg.sv
// shared types, constants and calendar tables for the day difference core
package gdd_pkg;

    localparam int YEAR_W = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W = 5;
    localparam int DNUM_W = 22;
    localparam int DIFF_W = 23;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2**14
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int PROD_W = YEAR_W + RECIP_W;
    localparam int Q100_W = 8;

    typedef struct packed {
        logic [YEAR_W-1:0]  from_year;
        logic [MONTH_W-1:0] from_month;
        logic [DAY_W-1:0]   from_day;
        logic [YEAR_W-1:0]  to_year;
        logic [MONTH_W-1:0] to_month;
        logic [DAY_W-1:0]   to_day;
    } t_date_req;

    typedef struct packed {
        logic signed [DIFF_W-1:0] day_difference;
        logic                     date_invalid;
    } t_date_rsp;

    typedef struct packed {
        logic [DNUM_W-1:0] number;
        logic              ok;
    } t_day_info;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

>>> src/gdd_if.sv
// valid/ready channel interfaces for date pair requests and day difference results
interface gdd_req_if;
    logic                 valid;
    logic                 ready;
    gdd_pkg::t_date_req   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gdd_rsp_if;
    logic                 valid;
    logic                 ready;
    gdd_pkg::t_date_rsp   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/gdd_day_number.sv
// date check and day number counted from 0001-01-01
module gdd_day_number (
    input  logic [gdd_pkg::YEAR_W-1:0]  i_year,
    input  logic [gdd_pkg::MONTH_W-1:0] i_month,
    input  logic [gdd_pkg::DAY_W-1:0]   i_day,
    output gdd_pkg::t_day_info          o_info
);
    logic [gdd_pkg::YEAR_W-1:0]  prev_year;
    logic [gdd_pkg::PROD_W-1:0]  year_prod;
    logic [gdd_pkg::PROD_W-1:0]  prev_prod;
    logic [gdd_pkg::Q100_W-1:0]  year_q100;
    logic [gdd_pkg::Q100_W-1:0]  prev_q100;
    logic [gdd_pkg::YEAR_W:0]    year_cent;
    logic                        is_century;
    logic                        is_leap;
    logic [gdd_pkg::DAY_W-1:0]   len;
    logic                        year_ok;
    logic                        month_ok;
    logic                        day_ok;
    logic [gdd_pkg::DNUM_W-1:0]  base_days;
    logic [gdd_pkg::DNUM_W-1:0]  leap_days;
    logic [gdd_pkg::DNUM_W-1:0]  month_days;

    assign prev_year = i_year - 14'd1;

    assign year_prod = gdd_pkg::PROD_W'(i_year) * gdd_pkg::PROD_W'(gdd_pkg::RECIP_100);
    assign prev_prod = gdd_pkg::PROD_W'(prev_year) * gdd_pkg::PROD_W'(gdd_pkg::RECIP_100);
    assign year_q100 = year_prod[gdd_pkg::RECIP_SHIFT +: gdd_pkg::Q100_W];
    assign prev_q100 = prev_prod[gdd_pkg::RECIP_SHIFT +: gdd_pkg::Q100_W];

    assign year_cent  = (gdd_pkg::YEAR_W+1)'(year_q100) * (gdd_pkg::YEAR_W+1)'(100);
    assign is_century = (year_cent == {1'b0, i_year});
    assign is_leap    = ((i_year[1:0] == 2'd0) && !is_century)
                      || (is_century && (year_q100[1:0] == 2'd0));

    assign len      = gdd_pkg::month_len(i_month, is_leap);
    assign year_ok  = (i_year >= gdd_pkg::YEAR_MIN) && (i_year <= gdd_pkg::YEAR_MAX);
    assign month_ok = (i_month >= gdd_pkg::MONTH_JAN) && (i_month <= gdd_pkg::MONTH_DEC);
    assign day_ok   = (i_day != 5'd0) && (i_day <= len);

    // 365 per year plus the leap days of all earlier years
    assign base_days = gdd_pkg::DNUM_W'(prev_year) * gdd_pkg::DNUM_W'(365);
    assign leap_days = gdd_pkg::DNUM_W'(prev_year[gdd_pkg::YEAR_W-1:2])
                     - gdd_pkg::DNUM_W'(prev_q100)
                     + gdd_pkg::DNUM_W'(prev_q100[gdd_pkg::Q100_W-1:2]);
    assign month_days = gdd_pkg::DNUM_W'(gdd_pkg::days_before(i_month))
                      + gdd_pkg::DNUM_W'((i_month > gdd_pkg::MONTH_FEB) && is_leap)
                      + gdd_pkg::DNUM_W'(i_day);

    assign o_info.number = base_days + leap_days + month_days;
    assign o_info.ok     = year_ok && month_ok && day_ok;

endmodule

>>> src/gregorian_day_difference_core.sv
// top level of the gregorian day difference core
//
// i_req carries a start date and a target date (year, month, day each).
// o_rsp carries the signed day count from start to target and a flag that
// is set when either date has a bad year, month or day; the count is then 0.
// A transfer is a rising edge of i_clk with valid and ready both high.
//
// Three register stages: the input register, the day number register and
// the result register. A request passes through them in that order, and
// one request is taken every cycle while the receiver keeps up.
// The day number of each date is found in one pass through a constant
// reciprocal multiply and a month table, so nothing limits the rate.
//
// When o_rsp.ready is low the result register holds; the stages before it
// keep filling until all three are full, and only then i_req.ready drops.
// Synchronous reset empties all stages; the payload registers are not reset.
module gregorian_day_difference_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gdd_req_if.sink       i_req,
    gdd_rsp_if.source     o_rsp
);
    gdd_pkg::t_date_req    r_s1;
    logic                  r_s1_valid;
    gdd_pkg::t_day_info    r_from_info;
    gdd_pkg::t_day_info    r_to_info;
    logic                  r_s2_valid;
    gdd_pkg::t_date_rsp    r_out;
    logic                  r_out_valid;

    gdd_pkg::t_day_info    from_info;
    gdd_pkg::t_day_info    to_info;
    gdd_pkg::t_date_rsp    n_out;
    logic                  en_s1;
    logic                  en_s2;
    logic                  en_out;

    assign en_out = !r_out_valid || o_rsp.ready;
    assign en_s2  = !r_s2_valid || en_out;
    assign en_s1  = !r_s1_valid || en_s2;

    assign i_req.ready = en_s1;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    gdd_day_number u_from (
        .i_year  (r_s1.from_year),
        .i_month (r_s1.from_month),
        .i_day   (r_s1.from_day),
        .o_info  (from_info)
    );

    gdd_day_number u_to (
        .i_year  (r_s1.to_year),
        .i_month (r_s1.to_month),
        .i_day   (r_s1.to_day),
        .o_info  (to_info)
    );

    always_comb begin
        if (r_from_info.ok && r_to_info.ok) begin
            n_out.day_difference = $signed({1'b0, r_to_info.number})
                                 - $signed({1'b0, r_from_info.number});
            n_out.date_invalid   = 1'b0;
        end else begin
            n_out.day_difference = '0;
            n_out.date_invalid   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_s1) begin
                r_s1_valid <= i_req.valid;
            end
            if (en_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en_out) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1 && i_req.valid) begin
            r_s1 <= i_req.data;
        end
        if (en_s2 && r_s1_valid) begin
            r_from_info <= from_info;
            r_to_info   <= to_info;
        end
        if (en_out && r_s2_valid) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.date_invalid |-> r_out.day_difference == '0)
        else $error("invalid date with nonzero difference");

    a_equal_dates_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && en_out && r_from_info.ok && r_to_info.ok
            && (r_from_info.number == r_to_info.number)
        |=> r_out_valid && r_out.day_difference == '0)
        else $error("equal day numbers gave nonzero difference");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && en_s2 |=> r_s2_valid)
        else $error("item lost between input and day number stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_s1_valid && !r_s2_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule

>>> tb/sv/gdd_day_diff_checker.sv
// checker for the day difference core: predicts each result and compares it field by field
`timescale 1ns / 100ps

module gdd_day_diff_checker
    import gdd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    input  logic      i_req_ready,
    input  t_date_req i_req_data,
    input  logic      i_rsp_valid,
    input  logic      i_rsp_ready,
    input  t_date_rsp i_rsp_data,
    output int        o_mismatches,
    output int        o_outstanding
);

    t_date_rsp diff_queue[$];

    function automatic bit is_leap(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(int m, int y);
        int len;
        case (m)
            4, 6, 9, 11:     len = 30;
            int'(MONTH_FEB): len = is_leap(y) ? 29 : 28;
            default:         len = 31;
        endcase
        return len;
    endfunction

    function automatic bit date_legal(int y, int m, int d);
        if (y < int'(YEAR_MIN) || y > int'(YEAR_MAX))
            return 1'b0;
        if (m < int'(MONTH_JAN) || m > int'(MONTH_DEC))
            return 1'b0;
        return (d >= 1) && (d <= days_in_month(m, y));
    endfunction

    // days since the start of year one, first of january of year one being 1
    function automatic int ordinal_day(int y, int m, int d);
        int p;
        int n;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400 + d;
        for (int k = int'(MONTH_JAN); k < m; k++)
            n += days_in_month(k, y);
        return n;
    endfunction

    function automatic t_date_rsp predict_difference(t_date_req q);
        t_date_rsp r;
        int span;
        r.day_difference = '0;
        r.date_invalid = 1'b1;
        if (date_legal(int'(q.from_year), int'(q.from_month), int'(q.from_day)) &&
            date_legal(int'(q.to_year), int'(q.to_month), int'(q.to_day))) begin
            span = ordinal_day(int'(q.to_year), int'(q.to_month), int'(q.to_day)) -
                   ordinal_day(int'(q.from_year), int'(q.from_month), int'(q.from_day));
            r.day_difference = span[DIFF_W-1:0];
            r.date_invalid = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_date_rsp want;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready)
                diff_queue.push_back(predict_difference(i_req_data));
            if (i_rsp_valid && i_rsp_ready) begin
                if (diff_queue.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("unexpected result transfer: diff %0d invalid %0b",
                                 $signed(i_rsp_data.day_difference), i_rsp_data.date_invalid);
                    o_mismatches++;
                end else begin
                    want = diff_queue.pop_front();
                    if (want.day_difference !== i_rsp_data.day_difference ||
                        want.date_invalid !== i_rsp_data.date_invalid) begin
                        if (o_mismatches < 10)
                            $display("mismatch: want diff %0d inv %0b, got diff %0d inv %0b",
                                     $signed(want.day_difference), want.date_invalid,
                                     $signed(i_rsp_data.day_difference), i_rsp_data.date_invalid);
                        o_mismatches++;
                    end
                end
            end
        end
        o_outstanding <= diff_queue.size();
    end

endmodule

>>> tb/sv/tb_top.sv
// top of the day difference testbench: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_top;
    import gdd_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int QUIET_ITEMS = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   quiet = 1'b0;
    int   fail_count;
    int   outstanding;
    int   cycle_count = 0;

    gdd_req_if req_ch ();
    gdd_rsp_if rsp_ch ();

    always #10 i_clk = ~i_clk;

    gregorian_day_difference_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    gdd_day_diff_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_ch.valid),
        .i_req_ready   (req_ch.ready),
        .i_req_data    (req_ch.data),
        .i_rsp_valid   (rsp_ch.valid),
        .i_rsp_ready   (rsp_ch.ready),
        .i_rsp_data    (rsp_ch.data),
        .o_mismatches  (fail_count),
        .o_outstanding (outstanding)
    );

    function automatic t_date_req date_pair(int fy, int fm, int fd, int ty, int tm, int td);
        t_date_req item;
        item.from_year = fy[YEAR_W-1:0];
        item.from_month = fm[MONTH_W-1:0];
        item.from_day = fd[DAY_W-1:0];
        item.to_year = ty[YEAR_W-1:0];
        item.to_month = tm[MONTH_W-1:0];
        item.to_day = td[DAY_W-1:0];
        return item;
    endfunction

    // mostly anywhere, sometimes close to a century boundary
    function automatic int pick_year();
        int y;
        if ($urandom_range(0, 9) < 7)
            return int'($urandom_range(1, 9999));
        y = int'($urandom_range(0, 99)) * 100 + int'($urandom_range(0, 8)) - 4;
        return (y < 1) ? 1 : y;
    endfunction

    function automatic int pick_day();
        if ($urandom_range(0, 9) < 8)
            return int'($urandom_range(1, 28));
        return int'($urandom_range(29, 31));
    endfunction

    task automatic send_pair(input t_date_req item);
        req_ch.valid <= 1'b1;
        req_ch.data <= item;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
    endtask

    task automatic send_random_pair();
        int fy, fm, fd, ty, tm, td;
        if ($urandom_range(0, 99) < 15) begin
            send_pair(date_pair($urandom_range(0, 16383), $urandom_range(0, 15),
                                $urandom_range(0, 31), $urandom_range(0, 16383),
                                $urandom_range(0, 15), $urandom_range(0, 31)));
        end else begin
            fy = pick_year();
            fm = int'($urandom_range(1, 12));
            fd = pick_day();
            tm = int'($urandom_range(1, 12));
            td = pick_day();
            case ($urandom_range(0, 3))
                0: ty = pick_year();
                1: begin
                    ty = fy;
                    if ($urandom_range(0, 1) == 0)
                        tm = fm;
                end
                default: begin
                    ty = fy + int'($urandom_range(0, 6)) - 3;
                    if (ty < 1)
                        ty = 1;
                    if (ty > 9999)
                        ty = 9999;
                end
            endcase
            send_pair(date_pair(fy, fm, fd, ty, tm, td));
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (outstanding != 0);
    endtask

    initial begin : rsp_stalls
        int gap;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 4) == 0) begin
                gap = int'($urandom_range(1, 13));
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top: errors");
        $finish;
    end

    initial begin : stimulus
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // widest spans, equal dates and leap days
        send_pair(date_pair(1, 1, 1, 9999, 12, 31));
        send_pair(date_pair(9999, 12, 31, 1, 1, 1));
        send_pair(date_pair(2024, 2, 29, 2024, 2, 29));
        send_pair(date_pair(2000, 2, 29, 2001, 3, 1));
        send_pair(date_pair(1600, 2, 29, 1700, 2, 28));
        send_pair(date_pair(2100, 3, 1, 2100, 2, 28));
        send_pair(date_pair(1999, 12, 31, 2000, 1, 1));
        // same year, different month, both directions, and same month, then a long backward span
        send_pair(date_pair(2023, 1, 15, 2023, 5, 10));
        send_pair(date_pair(2023, 5, 10, 2023, 1, 15));
        send_pair(date_pair(2023, 6, 3, 2023, 6, 28));
        send_pair(date_pair(2000, 1, 31, 2000, 12, 31));
        send_pair(date_pair(9999, 11, 30, 1, 1, 1));
        // bad days, months and years
        send_pair(date_pair(1900, 2, 29, 1900, 3, 1));
        send_pair(date_pair(2023, 2, 29, 2023, 3, 1));
        send_pair(date_pair(2024, 3, 1, 2024, 2, 30));
        send_pair(date_pair(2000, 4, 31, 2000, 5, 1));
        send_pair(date_pair(2000, 1, 0, 2000, 1, 1));
        send_pair(date_pair(2000, 0, 1, 2000, 1, 1));
        send_pair(date_pair(2000, 13, 1, 2000, 1, 1));
        send_pair(date_pair(2000, 1, 1, 2000, 15, 1));
        send_pair(date_pair(0, 1, 1, 2000, 1, 1));
        send_pair(date_pair(2000, 1, 1, 10000, 1, 1));
        send_pair(date_pair(16383, 15, 31, 16383, 15, 31));
        send_pair(date_pair(0, 0, 0, 0, 0, 0));

        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            send_random_pair();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
